/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* hw/rtl/sacm_pkg.sv */
// ----------------------------------------------------------------------------
// sacm_pkg
// Shared constants and types of the MRU set-associative tag store.
// ----------------------------------------------------------------------------
package sacm_pkg;

   localparam int ADDR_PORT_W = 64;  // width of the access address beat
   localparam int CNT_W       = 32;  // access / miss totals
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;

   localparam int OFFSET_BITS_W = 5;
   localparam int SET_BITS_W    = 3;
   localparam int WAY_BITS_W    = 2;

   localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd4;
   localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
   localparam logic [WAY_BITS_W-1:0]    WAY_BITS_RST    = 2'd1;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAY_BITS = 2;
   localparam int DEF_ADDR_BITS    = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_SET_BITS    = 2'd1,
      CSR_WAY_BITS    = 2'd2
   } csr_index_type;

endpackage

/* hw/rtl/sacm_ram.sv */
// ----------------------------------------------------------------------------
// sacm_ram
// One-port-read, one-port-write synchronous RAM with per-lane write enables
// and a registered read.
// ----------------------------------------------------------------------------
module sacm_ram #(
   parameter int ADDR_W = 6,
   parameter int LANES  = 4,
   parameter int LANE_W = 64
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [LANES-1:0][LANE_W-1:0]   rd_data,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [LANES-1:0]               wr_lane_en,
   input  logic [LANE_W-1:0]              wr_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [LANES-1:0][LANE_W-1:0] mem_ff [DEPTH];
   logic [LANES-1:0][LANE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (wr_lane_en[l]) begin
            mem_ff[wr_addr][l] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sacm_lookup.sv */
// ----------------------------------------------------------------------------
// sacm_lookup
// Parallel tag compare over one set plus victim choice: lowest invalid way
// in use, else the set's MRU way.
// ----------------------------------------------------------------------------
module sacm_lookup #(
   parameter int MAX_WAY_BITS = 2,
   parameter int TAG_W        = 64
) (
   input  logic [(1<<MAX_WAY_BITS)-1:0][TAG_W-1:0]           tag_row,
   input  logic [(1<<MAX_WAY_BITS)-1:0]                      valid_row,
   input  logic [((MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1)-1:0] mru_way,
   input  logic [TAG_W-1:0]                                  tag,
   input  logic [sacm_pkg::WAY_BITS_W-1:0]                   way_bits,
   output logic                                              hit,
   output logic [((MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1)-1:0] sel_way
);

   localparam int NWAYS = 1 << MAX_WAY_BITS;
   localparam int WAY_W = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;

   logic [WAY_W:0]     ways_used;
   logic [NWAYS-1:0]   in_use;
   logic [NWAYS-1:0]   match;
   logic               free_found;
   logic [WAY_W-1:0]   hit_way;
   logic [WAY_W-1:0]   victim;

   always_comb begin
      ways_used = (WAY_W+1)'(1) << way_bits;
      for (int w = 0; w < NWAYS; w++) begin
         in_use[w] = (WAY_W+1)'(w) < ways_used;
         match[w]  = in_use[w] & valid_row[w] & (tag_row[w] == tag);
      end

      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < NWAYS; w++) begin
         if (!hit && match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      // fall back to MRU only when every way in use is filled
      free_found = 1'b0;
      victim     = mru_way & WAY_W'(ways_used - 1'b1);
      for (int w = 0; w < NWAYS; w++) begin
         if (!free_found && in_use[w] && !valid_row[w]) begin
            free_found = 1'b1;
            victim     = WAY_W'(w);
         end
      end

      sel_way = hit ? hit_way : victim;
   end

endmodule

/* hw/rtl/set_assoc_cache_mru.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_mru
// Tag store of a set-associative cache with MRU replacement and hit/miss
// totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one access address per beat; rsp_* returns one beat per
//   access with the hit flag and the saturating access and miss totals.
//   A beat moves when valid is high and stall is low.
//   The request edge loads the lookup stage and the registered RAM reads;
//   the lookup then loads the output register, which presents the result.
//   Throughput: one access per cycle sustained while rsp_stall is low.
//   The set's tag row and MRU pointer are read from RAM at the request edge
//   and written back when its lookup completes; a back-to-back access to
//   the same set takes the written values from a forwarding register.
//   When rsp_stall holds a result, the lookup in flight waits and req_stall
//   rises until the output register frees.
//   csr_* writes offset_bits, set_bits or way_bits (index 0, 1, 2); the user
//   must write them only while the block is idle, which the block does not
//   enforce. Any such write, like reset, clears the valid bits and both
//   totals. Writes to other indexes are ignored. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_mru #(
   parameter int MAX_SET_BITS = sacm_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAY_BITS = sacm_pkg::DEF_MAX_WAY_BITS,
   parameter int ADDR_BITS    = sacm_pkg::DEF_ADDR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sacm_pkg::ADDR_PORT_W-1:0]    req_address,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sacm_pkg::CNT_W-1:0]          rsp_access_total,
   output logic [sacm_pkg::CNT_W-1:0]          rsp_miss_total,

   input  logic                                csr_wr_en,
   input  logic [sacm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NSETS = 1 << SET_W;
   localparam int WAY_W = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;
   localparam int NWAYS = 1 << MAX_WAY_BITS;
   localparam int TAG_W = ADDR_BITS;
   localparam int CNT_W = sacm_pkg::CNT_W;

   // configuration
   logic [sacm_pkg::OFFSET_BITS_W-1:0] offset_bits_ff;
   logic [sacm_pkg::SET_BITS_W-1:0]    set_bits_ff;
   logic [sacm_pkg::WAY_BITS_W-1:0]    way_bits_ff;
   logic                               cfg_clear;

   logic [sacm_pkg::SET_BITS_W-1:0]    sb_eff;
   logic [sacm_pkg::WAY_BITS_W-1:0]    wb_eff;

   // address split
   logic [ADDR_BITS-1:0] addr;
   logic [ADDR_BITS-1:0] above;
   logic [SET_W:0]       one_sh;
   logic [SET_W-1:0]     set_mask;
   logic [SET_W-1:0]     req_set;
   logic [TAG_W-1:0]     req_tag;

   // lookup stage
   logic                 lk_valid_ff;
   logic [SET_W-1:0]     lk_set_ff;
   logic [TAG_W-1:0]     lk_tag_ff;
   logic                 accept;
   logic                 complete;

   // write-back forwarding for a same-set access accepted at the write-back edge
   logic                 fwd_ff;
   logic                 fwd_tag_we_ff;
   logic [WAY_W-1:0]     fwd_way_ff;
   logic [TAG_W-1:0]     fwd_tag_ff;
   logic                 fwd_in;

   logic [NWAYS-1:0][TAG_W-1:0] tag_rd;
   logic [NWAYS-1:0][TAG_W-1:0] tag_row;
   logic [0:0][WAY_W-1:0]       mru_rd;
   logic [WAY_W-1:0]            mru_way;
   logic [NWAYS-1:0]            valid_ff [NSETS];

   logic                 lk_hit;
   logic [WAY_W-1:0]     lk_way;
   logic [NWAYS-1:0]     tag_lane_en;

   logic [CNT_W-1:0]     acc_cnt_ff;
   logic [CNT_W-1:0]     miss_cnt_ff;
   logic [CNT_W-1:0]     acc_cnt_in;
   logic [CNT_W-1:0]     miss_cnt_in;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [CNT_W-1:0]     rsp_acc_ff;
   logic [CNT_W-1:0]     rsp_miss_ff;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_clear = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            sacm_pkg::CSR_OFFSET_BITS,
            sacm_pkg::CSR_SET_BITS,
            sacm_pkg::CSR_WAY_BITS: cfg_clear = 1'b1;
            default:                cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= sacm_pkg::OFFSET_BITS_RST;
         set_bits_ff    <= sacm_pkg::SET_BITS_RST;
         way_bits_ff    <= sacm_pkg::WAY_BITS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sacm_pkg::CSR_OFFSET_BITS:
               offset_bits_ff <= csr_wdata[sacm_pkg::OFFSET_BITS_W-1:0];
            sacm_pkg::CSR_SET_BITS:
               set_bits_ff <= csr_wdata[sacm_pkg::SET_BITS_W-1:0];
            sacm_pkg::CSR_WAY_BITS:
               way_bits_ff <= csr_wdata[sacm_pkg::WAY_BITS_W-1:0];
            default: ;
         endcase
      end
   end

   assign sb_eff = (int'(set_bits_ff) > MAX_SET_BITS) ?
                   sacm_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_ff;
   assign wb_eff = (int'(way_bits_ff) > MAX_WAY_BITS) ?
                   sacm_pkg::WAY_BITS_W'(MAX_WAY_BITS) : way_bits_ff;

   // ---------------------------------------------------------------------
   // address split: offset | set | tag
   // ---------------------------------------------------------------------
   always_comb begin
      addr     = req_address[ADDR_BITS-1:0];
      above    = addr >> offset_bits_ff;
      one_sh   = (SET_W+1)'(1) << sb_eff;
      set_mask = SET_W'(one_sh - 1'b1);
      req_set  = above[SET_W-1:0] & set_mask;
      req_tag  = above >> sb_eff;
   end

   // ---------------------------------------------------------------------
   // handshake and lookup stage
   // ---------------------------------------------------------------------
   assign complete  = lk_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = lk_valid_ff & ~complete;
   assign accept    = req_valid & ~req_stall;
   assign fwd_in    = complete & (req_set == lk_set_ff);

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         lk_valid_ff <= 1'b0;
      end else if (accept) begin
         lk_valid_ff <= 1'b1;
      end else if (complete) begin
         lk_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (accept) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lk_set_ff     <= req_set;
         lk_tag_ff     <= req_tag;
         fwd_tag_we_ff <= ~lk_hit;
         fwd_way_ff    <= lk_way;
         fwd_tag_ff    <= lk_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // tag and MRU memories
   // ---------------------------------------------------------------------
   assign tag_lane_en = (complete && !lk_hit) ? (NWAYS'(1) << lk_way) : '0;

   sacm_ram #(
      .ADDR_W (SET_W),
      .LANES  (NWAYS),
      .LANE_W (TAG_W)
   ) u_tag_ram (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (req_set),
      .rd_data    (tag_rd),
      .wr_addr    (lk_set_ff),
      .wr_lane_en (tag_lane_en),
      .wr_data    (lk_tag_ff)
   );

   sacm_ram #(
      .ADDR_W (SET_W),
      .LANES  (1),
      .LANE_W (WAY_W)
   ) u_mru_ram (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (req_set),
      .rd_data    (mru_rd),
      .wr_addr    (lk_set_ff),
      .wr_lane_en (complete),
      .wr_data    (lk_way)
   );

   always_comb begin
      tag_row = tag_rd;
      if (fwd_ff && fwd_tag_we_ff) begin
         tag_row[fwd_way_ff] = fwd_tag_ff;
      end
      mru_way = fwd_ff ? fwd_way_ff : mru_rd[0];
   end

   sacm_lookup #(
      .MAX_WAY_BITS (MAX_WAY_BITS),
      .TAG_W        (TAG_W)
   ) u_lookup (
      .tag_row   (tag_row),
      .valid_row (valid_ff[lk_set_ff]),
      .mru_way   (mru_way),
      .tag       (lk_tag_ff),
      .way_bits  (wb_eff),
      .hit       (lk_hit),
      .sel_way   (lk_way)
   );

   // valid bits live in flops so reset and config clear them at once
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         for (int s = 0; s < NSETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (complete && !lk_hit) begin
         valid_ff[lk_set_ff][lk_way] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // saturating totals and output register
   // ---------------------------------------------------------------------
   assign acc_cnt_in  = (&acc_cnt_ff) ? acc_cnt_ff : acc_cnt_ff + 1'b1;
   assign miss_cnt_in = (lk_hit || (&miss_cnt_ff)) ? miss_cnt_ff : miss_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         acc_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (complete) begin
         acc_cnt_ff  <= acc_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (complete) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (complete) begin
         rsp_hit_ff  <= lk_hit;
         rsp_acc_ff  <= acc_cnt_in;
         rsp_miss_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_access_total = rsp_acc_ff;
   assign rsp_miss_total   = rsp_miss_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `ASSERT_NEVER(a_miss_le_access, clock, reset,
                 miss_cnt_ff > acc_cnt_ff, "miss total above access total")
   `ASSERT_PROP(a_miss_counts, clock, reset,
                (complete && !lk_hit && !(&miss_cnt_ff) && !cfg_clear) |=>
                (miss_cnt_ff == $past(miss_cnt_ff) + 1'b1), "miss not counted")
   `ASSERT_PROP(a_result_loaded, clock, reset,
                (complete && !cfg_clear) |=> (rsp_valid_ff && (rsp_acc_ff != '0)),
                "lookup finished without a result")

endmodule

/* test/tb_set_assoc_cache_mru.sv */
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_mru
// Self-checking bench for the MRU set-associative tag store. A scoreboard
// class keeps its own copy of tags, valid bits, MRU pointers and totals,
// predicts every response beat and compares it field by field. Directed
// accesses cover fill order, MRU eviction, clamped geometry and an ignored
// register write; random phases follow under several register settings,
// with random gaps on requests and random response stalls but in the last phase.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_mru;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SB         = sacm_pkg::DEF_MAX_SET_BITS;
   localparam int MAX_WB         = sacm_pkg::DEF_MAX_WAY_BITS;
   localparam int ADDR_W         = sacm_pkg::ADDR_PORT_W;
   localparam int CNT_W          = sacm_pkg::CNT_W;
   localparam int IDX_W          = sacm_pkg::CSR_IDX_W;
   localparam int DATA_W         = sacm_pkg::CSR_DATA_W;
   localparam int NUM_SETS       = 1 << MAX_SB;
   localparam int NUM_WAYS       = 1 << MAX_WB;
   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BEATS    = 75;
   localparam int NUM_PHASES     = 6;
   // no register lives at the last index; a write there must change nothing
   localparam logic [IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      bit             hit;
      bit [CNT_W-1:0] access_total;
      bit [CNT_W-1:0] miss_total;
   } lookup_result_type;

   class mru_tag_scoreboard_type;
      bit [sacm_pkg::OFFSET_BITS_W-1:0] offset_bits;
      bit [sacm_pkg::SET_BITS_W-1:0]    set_bits;
      bit [sacm_pkg::WAY_BITS_W-1:0]    way_bits;
      bit [ADDR_W-1:0]        tag_mem [NUM_SETS][NUM_WAYS];
      bit                     line_valid [NUM_SETS][NUM_WAYS];
      bit [MAX_WB-1:0]        recent [NUM_SETS];
      bit [CNT_W-1:0]         accesses;
      bit [CNT_W-1:0]         misses;
      lookup_result_type      expected_q [$];
      int                     mismatches;
      int                     beats_checked;
      int                     hits_seen;

      function new();
         offset_bits = sacm_pkg::OFFSET_BITS_RST;
         set_bits    = sacm_pkg::SET_BITS_RST;
         way_bits    = sacm_pkg::WAY_BITS_RST;
         mismatches  = 0;
         beats_checked = 0;
         hits_seen   = 0;
         clear();
      endfunction

      function void clear();
         foreach (line_valid[s, w]) line_valid[s][w] = 1'b0;
         foreach (recent[s]) recent[s] = '0;
         accesses = '0;
         misses   = '0;
      endfunction

      function int unsigned set_bits_used();
         return (set_bits > MAX_SB) ? MAX_SB : set_bits;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         unique case (idx)
            sacm_pkg::CSR_OFFSET_BITS:
               offset_bits = data[sacm_pkg::OFFSET_BITS_W-1:0];
            sacm_pkg::CSR_SET_BITS:
               set_bits    = data[sacm_pkg::SET_BITS_W-1:0];
            sacm_pkg::CSR_WAY_BITS:
               way_bits    = data[sacm_pkg::WAY_BITS_W-1:0];
            default: return;
         endcase
         clear();
      endfunction

      function void note_access(bit [ADDR_W-1:0] addr);
         int unsigned          sb;
         int unsigned          ways;
         int unsigned          set_idx;
         int unsigned          victim;
         int unsigned          w;
         bit [ADDR_W-1:0]      upper;
         bit [ADDR_W-1:0]      tag;
         bit                   hit;
         bit                   found;
         lookup_result_type    r;
         sb   = set_bits_used();
         ways = 1 << ((way_bits > MAX_WB) ? MAX_WB : way_bits);
         upper   = addr >> offset_bits;
         set_idx = 32'(upper & ((64'd1 << sb) - 64'd1));
         tag     = upper >> sb;
         hit     = 1'b0;
         found   = 1'b0;
         if (accesses != '1) accesses++;
         for (w = 0; w < ways; w++) begin
            if (!hit && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
               hit = 1'b1;
               recent[set_idx] = MAX_WB'(w);
            end
         end
         if (!hit) begin
            if (misses != '1) misses++;
            // lowest invalid way first, the MRU way only when the set is full
            victim = recent[set_idx] & (ways - 1);
            for (w = 0; w < ways; w++) begin
               if (!found && !line_valid[set_idx][w]) begin
                  victim = w;
                  found  = 1'b1;
               end
            end
            line_valid[set_idx][victim] = 1'b1;
            tag_mem[set_idx][victim]    = tag;
            recent[set_idx]             = MAX_WB'(victim);
         end else begin
            hits_seen++;
         end
         r.hit          = hit;
         r.access_total = accesses;
         r.miss_total   = misses;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic hit, logic [CNT_W-1:0] acc, logic [CNT_W-1:0] miss);
         lookup_result_type e;
         beats_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("beat %0d: unexpected response hit=%0b access=%0d miss=%0d",
                        beats_checked, hit, acc, miss);
            return;
         end
         e = expected_q.pop_front();
         if (hit !== e.hit || acc !== e.access_total || miss !== e.miss_total) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("beat %0d: exp hit=%0b acc=%0d miss=%0d, got hit=%0b acc=%0d miss=%0d",
                        beats_checked, e.hit, e.access_total, e.miss_total, hit, acc, miss);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ADDR_W-1:0]      req_address = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_hit;
   logic [CNT_W-1:0]       rsp_access_total;
   logic [CNT_W-1:0]       rsp_miss_total;
   logic                   csr_wr_en = 1'b0;
   logic [IDX_W-1:0]       csr_index = '0;
   logic [DATA_W-1:0]      csr_wdata = '0;

   mru_tag_scoreboard_type tag_model;
   bit                idling = 1'b1;
   int                stall_left = 0;
   int                quiet_cycles = 0;
   int                reg_writes = 0;

   set_assoc_cache_mru uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_miss_total   (rsp_miss_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial tag_model = new();

   // response side: random stall bursts, begun only while idling is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // beats on both channels; response checked before the new request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tag_model.check_result(rsp_hit, rsp_access_total, rsp_miss_total);
         if (req_valid && !req_stall)
            tag_model.note_access(req_address);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_access(input bit [ADDR_W-1:0] addr);
      int unsigned gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tag_model.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_reg(input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tag_model.write_reg(idx, data);
      reg_writes++;
   endtask

   task automatic run_phase(input int beats);
      bit [ADDR_W-1:0]      pool_tag [8];
      int unsigned          pool_set [8];
      int unsigned          hot_set [3];
      int unsigned          sb;
      int unsigned          off;
      int unsigned          k;
      bit [ADDR_W-1:0]      low_mask;
      bit [ADDR_W-1:0]      addr;
      sb  = tag_model.set_bits_used();
      off = tag_model.offset_bits;
      low_mask = (64'd1 << off) - 64'd1;
      foreach (hot_set[i]) hot_set[i] = $urandom_range(0, (1 << sb) - 1);
      foreach (pool_tag[i]) begin
         pool_tag[i] = {$urandom, $urandom};
         pool_set[i] = hot_set[$urandom_range(0, 2)];
      end
      // mostly a small pool crowded into few sets, so hits and evictions occur
      for (int n = 0; n < beats; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            k    = $urandom_range(0, 7);
            addr = (pool_tag[k] << (off + sb)) | (64'(pool_set[k]) << off)
                 | ({$urandom, $urandom} & low_mask);
         end else begin
            addr = {$urandom, $urandom};
         end
         send_access(addr);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry: 16 sets, 2 ways, 16-byte lines
      send_access(64'h0);
      send_access(64'h0);
      send_access(64'hF);
      send_access(64'h100);                  // fills way 1 of set 0
      send_access(64'h200);                  // set full: evicts MRU way 1
      send_access(64'h0);
      send_access(64'h200);
      send_access(64'h100);
      send_access(64'hFFFF_FFFF_FFFF_FFFF);
      send_access(64'hFFFF_FFFF_FFFF_FFFF);
      send_access(64'h8000_0000_0000_0000);
      send_access(64'h5555_5555_5555_5555);
      send_access(64'hAAAA_AAAA_AAAA_AAAA);

      // write to an unused index leaves the contents alone
      program_reg(CSR_UNUSED_IDX, '1);
      send_access(64'hFFFF_FFFF_FFFF_FFFF);

      // direct mapped, one set, byte lines
      program_reg(sacm_pkg::CSR_OFFSET_BITS, 5'd0);
      program_reg(sacm_pkg::CSR_SET_BITS, 5'd0);
      program_reg(sacm_pkg::CSR_WAY_BITS, 5'd0);
      send_access(64'h0);
      send_access(64'h1);
      send_access(64'h1);
      send_access(64'h0);

      // oversized set and way counts clamp to the maximum geometry; offset 31 is used as written
      program_reg(sacm_pkg::CSR_OFFSET_BITS, 5'd31);
      program_reg(sacm_pkg::CSR_SET_BITS, 5'd31);
      program_reg(sacm_pkg::CSR_WAY_BITS, 5'd31);
      send_access(64'hFFFF_FFFF_FFFF_FFFF);
      send_access(64'h7FFF_FFFF);
      send_access(64'h0);
      send_access(64'h8000_0000);
      send_access(64'hFFFF_FFFF_FFFF_FFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 0) begin
            program_reg(sacm_pkg::CSR_OFFSET_BITS, 5'd16);
            program_reg(sacm_pkg::CSR_SET_BITS, 5'd6);
            program_reg(sacm_pkg::CSR_WAY_BITS, 5'd2);
         end else begin
            program_reg(sacm_pkg::CSR_OFFSET_BITS, DATA_W'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(17, 31) : $urandom_range(0, 16)));
            program_reg(sacm_pkg::CSR_SET_BITS, DATA_W'($urandom_range(0, 31)));
            program_reg(sacm_pkg::CSR_WAY_BITS, DATA_W'($urandom_range(0, 31)));
         end
         if (p == NUM_PHASES - 1) idling = 1'b0;
         run_phase(PHASE_BEATS);
      end

      drain();
      $display("Checked %0d lookups (%0d hits) across %0d register writes,",
               tag_model.beats_checked, tag_model.hits_seen, reg_writes);
      $display("including clamped set/way counts, offsets up to 31 and an ignored index.");
      if (tag_model.mismatches == 0 && tag_model.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* set_assoc_cache_mru.f */
+incdir+hw/rtl
hw/rtl/sacm_pkg.sv
hw/rtl/sacm_ram.sv
hw/rtl/sacm_lookup.sv
hw/rtl/set_assoc_cache_mru.sv
test/tb_set_assoc_cache_mru.sv
